// ===== rtl/sha1bs_pkg.sv =====
// Shared constants, types and helpers for the SHA-1 byte stream hasher.
package sha1bs_pkg;

    localparam int BYTE_W     = 8;
    localparam int WORD_W     = 32;
    localparam int NUM_H      = 5;
    localparam int WORD_NUM_W = 3;
    localparam int FILL_W     = 6;
    localparam int LEN_W      = 61;
    localparam int ROUND_W    = 7;
    localparam int SCHED_N    = 16;

    typedef logic [BYTE_W-1:0]     byte_t;
    typedef logic [WORD_W-1:0]     word_t;
    typedef logic [WORD_NUM_W-1:0] word_num_t;
    typedef logic [FILL_W-1:0]     fill_t;
    typedef logic [LEN_W-1:0]      len_t;
    typedef logic [ROUND_W-1:0]    round_t;

    localparam word_num_t LAST_WORD = word_num_t'(NUM_H - 1);

    localparam word_t INIT_H [NUM_H] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam word_t K0 = 32'h5A827999;
    localparam word_t K1 = 32'h6ED9EBA1;
    localparam word_t K2 = 32'h8F1BBCDC;
    localparam word_t K3 = 32'hCA62C1D6;

    localparam byte_t PAD_BYTE = 8'h80;
    localparam fill_t LEN_POS  = 6'd56;
    localparam fill_t LAST_POS = 6'd63;

    localparam round_t ROUND_B1   = 7'd20;
    localparam round_t ROUND_B2   = 7'd40;
    localparam round_t ROUND_B3   = 7'd60;
    localparam round_t ROUND_LAST = 7'd79;

    function automatic word_t rotl1(input word_t v);
        rotl1 = {v[WORD_W-2:0], v[WORD_W-1]};
    endfunction

    function automatic word_t rotl5(input word_t v);
        rotl5 = {v[WORD_W-6:0], v[WORD_W-1:WORD_W-5]};
    endfunction

    function automatic word_t rotl30(input word_t v);
        rotl30 = {v[1:0], v[WORD_W-1:2]};
    endfunction

endpackage

// ===== rtl/sha1bs_if.sv =====
// Request channels of the SHA-1 hasher: byte intake and digest output.
interface sha1bs_byte_if;
    logic                 valid;
    logic                 ready;
    sha1bs_pkg::byte_t    message_byte;
    logic                 byte_present;
    logic                 message_end;

    modport source (output valid, message_byte, byte_present, message_end, input ready);
    modport sink   (input valid, message_byte, byte_present, message_end, output ready);
endinterface

interface sha1bs_digest_if;
    logic                  valid;
    logic                  ready;
    sha1bs_pkg::word_t     digest_word;
    sha1bs_pkg::word_num_t word_number;
    logic                  final_word;

    modport source (output valid, digest_word, word_number, final_word, input ready);
    modport sink   (input valid, digest_word, word_number, final_word, output ready);
endinterface

// ===== rtl/sha1_byte_stream_hasher.sv =====
// SHA-1 hasher taking one message byte per request, one round per cycle.
//
// byte_ch carries requests of one optional byte plus an end-of-message mark.
// digest_ch returns five 32-bit digest words, word 0 first, final_word on word 4.
// Every 64th byte (and the block closed by padding) starts the compression:
// the single round unit runs rounds 0 to 79, then ST_ADD folds the result into
// the chaining words; byte_ch is not ready meanwhile.
// After an end mark the block writes 0x80 and zero bytes up to position 56,
// moves on at position 56 to write two length words, compresses (twice when
// the padding spills into a new block) and then offers the five digest words,
// one per cycle while digest_ch is ready.
// A stalled digest_ch holds the current word and keeps byte_ch not ready.
// Once word 4 is taken the chaining words and length return to their initial
// values and byte_ch is ready in the next cycle.
// Reset (rst_n low) loads the initial chaining values, clears the length and
// fill count and leaves the block idle and ready.
module sha1_byte_stream_hasher (
    input  logic                   clk,
    input  logic                   rst_n,
    sha1bs_byte_if.sink            byte_ch,
    sha1bs_digest_if.source        digest_ch
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PAD    = 3'd1;
    localparam logic [2:0] ST_LEN_HI = 3'd2;
    localparam logic [2:0] ST_LEN_LO = 3'd3;
    localparam logic [2:0] ST_ROUND  = 3'd4;
    localparam logic [2:0] ST_ADD    = 3'd5;
    localparam logic [2:0] ST_OUT    = 3'd6;

    logic [2:0]            state_reg, state_next;
    logic [2:0]            ret_reg, ret_next;
    logic                  pad_first_reg, pad_first_next;
    sha1bs_pkg::fill_t     fill_reg, fill_next;
    sha1bs_pkg::len_t      len_reg, len_next;
    sha1bs_pkg::round_t    round_reg, round_next;
    sha1bs_pkg::word_num_t word_reg, word_next;
    sha1bs_pkg::word_t     h_reg [sha1bs_pkg::NUM_H];
    sha1bs_pkg::word_t     h_next [sha1bs_pkg::NUM_H];
    sha1bs_pkg::word_t     s_reg [sha1bs_pkg::SCHED_N];
    sha1bs_pkg::word_t     s_next [sha1bs_pkg::SCHED_N];
    logic [23:0]           acc_reg, acc_next;
    sha1bs_pkg::word_t     a_reg, b_reg, c_reg, d_reg, e_reg;
    sha1bs_pkg::word_t     a_next, b_next, c_next, d_next, e_next;

    logic                  put_en;
    sha1bs_pkg::byte_t     put_val;
    logic                  push_en;
    sha1bs_pkg::word_t     push_word;
    logic                  start_cmp;
    sha1bs_pkg::word_t     f_val, k_val, t_val, w_new;

    assign byte_ch.ready         = (state_reg == ST_IDLE);
    assign digest_ch.valid       = (state_reg == ST_OUT);
    assign digest_ch.digest_word = h_reg[word_reg];
    assign digest_ch.word_number = word_reg;
    assign digest_ch.final_word  = (word_reg == sha1bs_pkg::LAST_WORD);

    always_comb
    begin
        if (round_reg < sha1bs_pkg::ROUND_B1)
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = sha1bs_pkg::K0;
        end
        else if (round_reg < sha1bs_pkg::ROUND_B2)
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1bs_pkg::K1;
        end
        else if (round_reg < sha1bs_pkg::ROUND_B3)
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = sha1bs_pkg::K2;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = sha1bs_pkg::K3;
        end
        t_val = sha1bs_pkg::rotl5(a_reg) + f_val + e_reg + k_val + s_reg[0];
        w_new = sha1bs_pkg::rotl1(s_reg[13] ^ s_reg[8] ^ s_reg[2] ^ s_reg[0]);
    end

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        pad_first_next = pad_first_reg;
        fill_next      = fill_reg;
        len_next       = len_reg;
        round_next     = round_reg;
        word_next      = word_reg;
        h_next         = h_reg;
        s_next         = s_reg;
        acc_next       = acc_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        d_next         = d_reg;
        e_next         = e_reg;
        put_en         = 1'b0;
        put_val        = '0;
        push_en        = 1'b0;
        push_word      = '0;
        start_cmp      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (byte_ch.valid)
                begin
                    if (byte_ch.byte_present)
                    begin
                        put_en   = 1'b1;
                        put_val  = byte_ch.message_byte;
                        len_next = len_reg + 1'b1;
                    end
                    if (byte_ch.message_end)
                    begin
                        state_next     = ST_PAD;
                        pad_first_next = 1'b1;
                    end
                    if (byte_ch.byte_present && fill_reg == sha1bs_pkg::LAST_POS)
                    begin
                        start_cmp = 1'b1;
                        ret_next  = byte_ch.message_end ? ST_PAD : ST_IDLE;
                    end
                end
            end
            ST_PAD:
            begin
                if (!pad_first_reg && fill_reg == sha1bs_pkg::LEN_POS)
                begin
                    state_next = ST_LEN_HI;
                end
                else
                begin
                    put_en         = 1'b1;
                    put_val        = pad_first_reg ? sha1bs_pkg::PAD_BYTE : '0;
                    pad_first_next = 1'b0;
                    if (fill_reg == sha1bs_pkg::LAST_POS)
                    begin
                        start_cmp = 1'b1;
                        ret_next  = ST_PAD;
                    end
                end
            end
            ST_LEN_HI:
            begin
                push_en    = 1'b1;
                push_word  = len_reg[60:29];
                state_next = ST_LEN_LO;
            end
            ST_LEN_LO:
            begin
                push_en   = 1'b1;
                push_word = {len_reg[28:0], 3'b000};
                fill_next = '0;
                start_cmp = 1'b1;
                ret_next  = ST_OUT;
            end
            ST_ROUND:
            begin
                push_en   = 1'b1;
                push_word = w_new;
                a_next    = t_val;
                b_next    = a_reg;
                c_next    = sha1bs_pkg::rotl30(b_reg);
                d_next    = c_reg;
                e_next    = d_reg;
                if (round_reg == sha1bs_pkg::ROUND_LAST)
                    state_next = ST_ADD;
                else
                    round_next = round_reg + 1'b1;
            end
            ST_ADD:
            begin
                h_next[0]  = h_reg[0] + a_reg;
                h_next[1]  = h_reg[1] + b_reg;
                h_next[2]  = h_reg[2] + c_reg;
                h_next[3]  = h_reg[3] + d_reg;
                h_next[4]  = h_reg[4] + e_reg;
                word_next  = '0;
                state_next = ret_reg;
            end
            ST_OUT:
            begin
                if (digest_ch.ready)
                begin
                    if (word_reg == sha1bs_pkg::LAST_WORD)
                    begin
                        h_next     = sha1bs_pkg::INIT_H;
                        len_next   = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        word_next = word_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (put_en)
        begin
            fill_next = fill_reg + 1'b1;
            acc_next  = {acc_reg[15:0], put_val};
            if (fill_reg[1:0] == 2'b11)
            begin
                push_en   = 1'b1;
                push_word = {acc_reg, put_val};
            end
        end

        if (push_en)
        begin
            for (int i = 0; i < sha1bs_pkg::SCHED_N - 1; i++)
                s_next[i] = s_reg[i+1];
            s_next[sha1bs_pkg::SCHED_N-1] = push_word;
        end

        if (start_cmp)
        begin
            state_next = ST_ROUND;
            round_next = '0;
            a_next     = h_reg[0];
            b_next     = h_reg[1];
            c_next     = h_reg[2];
            d_next     = h_reg[3];
            e_next     = h_reg[4];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            pad_first_reg <= 1'b0;
            fill_reg      <= '0;
            len_reg       <= '0;
            round_reg     <= '0;
            word_reg      <= '0;
            h_reg         <= sha1bs_pkg::INIT_H;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            pad_first_reg <= pad_first_next;
            fill_reg      <= fill_next;
            len_reg       <= len_next;
            round_reg     <= round_next;
            word_reg      <= word_next;
            h_reg         <= h_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg   <= s_next;
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        c_reg   <= c_next;
        d_reg   <= d_next;
        e_reg   <= e_next;
    end

endmodule

// ===== rtl/sha1bs_checker.sv =====
// Port-level checks for the SHA-1 hasher, bound into sha1_byte_stream_hasher.
module sha1bs_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input sha1bs_pkg::word_num_t word_number,
    input logic                  final_word
);

    // no byte intake while a digest is on offer
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("byte channel ready while digest pending");

    a_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (final_word == (word_number == sha1bs_pkg::LAST_WORD)))
        else $error("final_word mismatch");

    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !final_word) |=>
            (out_valid && word_number == $past(word_number) + 3'd1))
        else $error("digest words out of sequence");

    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && final_word) |=> (in_ready && !out_valid))
        else $error("not idle after last digest word");

endmodule

bind sha1_byte_stream_hasher sha1bs_checker u_sha1bs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (byte_ch.ready),
    .out_valid   (digest_ch.valid),
    .out_ready   (digest_ch.ready),
    .word_number (digest_ch.word_number),
    .final_word  (digest_ch.final_word)
);

// ===== sim/tb.sv =====
// Self-checking bench for the SHA-1 byte stream hasher: byte requests in, digest words out.
`timescale 1ns / 100ps

module tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 300;
    localparam int STALL_LEN   = 300;
    localparam int RAND_REQS   = 260;

    typedef struct {
        sha1bs_pkg::byte_t data;
        logic              present;
        logic              last;
    } byte_req_t;

    typedef struct {
        sha1bs_pkg::word_t     word;
        sha1bs_pkg::word_num_t num;
        logic                  fin;
    } digest_exp_t;

    logic clk;
    logic rst_n;

    sha1bs_byte_if   byte_ch ();
    sha1bs_digest_if digest_ch ();

    sha1_byte_stream_hasher u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_ch   (byte_ch),
        .digest_ch (digest_ch)
    );

    byte_req_t   pending_req [$];
    digest_exp_t expected_digest [$];

    int          n_counted;
    int          n_total;
    int          n_accepted;
    int          error_count;
    int unsigned cycle_count;
    int unsigned stall_left;
    bit          stall_used;
    int          load_phase;

    // hash state mirror
    sha1bs_pkg::word_t hash_h [sha1bs_pkg::NUM_H];
    sha1bs_pkg::word_t blk_w [16];
    sha1bs_pkg::fill_t blk_fill;
    sha1bs_pkg::len_t  msg_len;

    function automatic sha1bs_pkg::word_t rol(sha1bs_pkg::word_t v, int unsigned n);
        return (v << n) | (v >> (sha1bs_pkg::WORD_W - n));
    endfunction

    function automatic void sha1_compress();
        sha1bs_pkg::word_t sched [80];
        sha1bs_pkg::word_t a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++)
            sched[i] = blk_w[i];
        for (int i = 16; i < 80; i++)
            sched[i] = rol(sched[i-3] ^ sched[i-8] ^ sched[i-14] ^ sched[i-16], 1);
        a = hash_h[0];
        b = hash_h[1];
        c = hash_h[2];
        d = hash_h[3];
        e = hash_h[4];
        for (int i = 0; i < 80; i++)
        begin
            if (i < 20)
            begin
                f = (b & c) | (~b & d);
                k = sha1bs_pkg::K0;
            end
            else if (i < 40)
            begin
                f = b ^ c ^ d;
                k = sha1bs_pkg::K1;
            end
            else if (i < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = sha1bs_pkg::K2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = sha1bs_pkg::K3;
            end
            t = rol(a, 5) + f + e + k + sched[i];
            e = d;
            d = c;
            c = rol(b, 30);
            b = a;
            a = t;
        end
        hash_h[0] += a;
        hash_h[1] += b;
        hash_h[2] += c;
        hash_h[3] += d;
        hash_h[4] += e;
    endfunction

    function automatic void put_byte(sha1bs_pkg::byte_t data);
        int unsigned pos, idx, sh;
        pos = 32'(blk_fill);
        idx = pos >> 2;
        sh  = (3 - (pos & 3)) * 8;
        if ((pos & 3) == 0)
            blk_w[idx] = sha1bs_pkg::word_t'(data) << sh;
        else
            blk_w[idx] |= sha1bs_pkg::word_t'(data) << sh;
        if (blk_fill == sha1bs_pkg::LAST_POS)
        begin
            sha1_compress();
            blk_fill = '0;
        end
        else
            blk_fill = blk_fill + 1'b1;
    endfunction

    function automatic void absorb_request(byte_req_t r);
        logic [63:0] bit_len;
        digest_exp_t x;
        if (r.present)
        begin
            put_byte(r.data);
            msg_len = msg_len + 1'b1;
        end
        if (r.last)
        begin
            bit_len = {msg_len, 3'b000};
            put_byte(sha1bs_pkg::PAD_BYTE);
            while (blk_fill != sha1bs_pkg::LEN_POS)
                put_byte(8'h00);
            blk_w[14] = bit_len[63:32];
            blk_w[15] = bit_len[31:0];
            sha1_compress();
            blk_fill = '0;
            for (int i = 0; i < sha1bs_pkg::NUM_H; i++)
            begin
                x.word = hash_h[i];
                x.num  = sha1bs_pkg::word_num_t'(i);
                x.fin  = (i == sha1bs_pkg::NUM_H - 1);
                expected_digest.push_back(x);
            end
            hash_h  = sha1bs_pkg::INIT_H;
            msg_len = '0;
        end
    endfunction

    task automatic add_req(sha1bs_pkg::byte_t data, logic present, logic last);
        byte_req_t r;
        r.data    = data;
        r.present = present;
        r.last    = last;
        pending_req.push_back(r);
        n_counted++;
    endtask

    // one message of len bytes with noise: idle requests with junk bytes scattered through it
    task automatic add_message(int len, bit end_on_byte);
        sha1bs_pkg::byte_t data;
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 99) < 8)
                add_req(sha1bs_pkg::byte_t'($urandom), 1'b0, 1'b0);
            case ($urandom_range(0, 9))
                0:       data = 8'h00;
                1:       data = 8'hFF;
                default: data = sha1bs_pkg::byte_t'($urandom);
            endcase
            add_req(data, 1'b1, end_on_byte && (i == len - 1));
        end
        if (!end_on_byte || len == 0)
            add_req(sha1bs_pkg::byte_t'($urandom), 1'b0, 1'b1);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        int len;
        rst_n = 1'b0;

        // directed
        add_req(8'h00, 1'b0, 1'b0);
        add_req(8'hA5, 1'b0, 1'b1);
        add_req(8'h61, 1'b1, 1'b0);
        add_req(8'h62, 1'b1, 1'b0);
        add_req(8'h63, 1'b1, 1'b0);
        add_req(8'hFF, 1'b0, 1'b1);
        add_req(8'hFF, 1'b0, 1'b0);
        add_req(8'hFF, 1'b1, 1'b1);
        add_req(8'h00, 1'b1, 1'b1);
        add_req(8'h5A, 1'b1, 1'b0);
        add_req(8'h00, 1'b0, 1'b0);
        add_req(8'hFF, 1'b0, 1'b1);

        // random messages, weighted towards the padding boundaries
        n_counted = 0;
        while (n_counted < RAND_REQS)
        begin
            if ($urandom_range(0, 99) < 25)
            begin
                case ($urandom_range(0, 7))
                    0:       len = 55;
                    1:       len = 56;
                    2:       len = 57;
                    3:       len = 63;
                    4:       len = 64;
                    5:       len = 65;
                    6:       len = 119;
                    default: len = 120;
                endcase
            end
            else
                len = $urandom_range(0, 12);
            if (len > RAND_REQS - n_counted)
                len = RAND_REQS - n_counted;
            add_message(len, 1'($urandom_range(0, 1)));
        end
        n_total = pending_req.size();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_req.size() != 0 || byte_ch.valid || expected_digest.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("sha1_byte_stream_hasher verification clean");
        else
            $display("sha1_byte_stream_hasher verification failed");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cycle_count <= 0;
        else
        begin
            cycle_count <= cycle_count + 1;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("%0t timeout after %0d cycles", $time, cycle_count);
                $display("sha1_byte_stream_hasher verification failed");
                $finish;
            end
        end
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        byte_req_t r;
        int        send_idle;
        if (!rst_n)
        begin
            byte_ch.valid        <= 1'b0;
            byte_ch.message_byte <= '0;
            byte_ch.byte_present <= 1'b0;
            byte_ch.message_end  <= 1'b0;
            load_phase           <= 0;
            n_accepted           = 0;
            hash_h               = sha1bs_pkg::INIT_H;
            blk_fill             = '0;
            msg_len              = '0;
            for (int i = 0; i < 16; i++)
                blk_w[i] = '0;
        end
        else
        begin
            if (byte_ch.valid && byte_ch.ready)
            begin
                r.data    = byte_ch.message_byte;
                r.present = byte_ch.byte_present;
                r.last    = byte_ch.message_end;
                absorb_request(r);
                n_accepted++;
            end
            if (n_accepted < n_total / 3)
                load_phase <= 0;
            else if (n_accepted < (2 * n_total) / 3)
                load_phase <= 1;
            else
                load_phase <= 2;
            case (load_phase)
                0:       send_idle = 19;
                1:       send_idle = 66;
                default: send_idle = 0;
            endcase
            if (!byte_ch.valid || byte_ch.ready)
            begin
                if (pending_req.size() != 0 && $urandom_range(0, 99) >= send_idle)
                begin
                    r = pending_req.pop_front();
                    byte_ch.valid        <= 1'b1;
                    byte_ch.message_byte <= r.data;
                    byte_ch.byte_present <= r.present;
                    byte_ch.message_end  <= r.last;
                end
                else
                    byte_ch.valid <= 1'b0;
            end
        end
    end

    // long hold-off on the digest side while requests keep coming
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stall_left <= 0;
            stall_used <= 1'b0;
        end
        else if (!stall_used && digest_ch.valid && pending_req.size() >= 30)
        begin
            stall_left <= STALL_LEN;
            stall_used <= 1'b1;
        end
        else if (stall_left != 0)
            stall_left <= stall_left - 1;
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        digest_exp_t x;
        int          recv_idle;
        if (!rst_n)
        begin
            digest_ch.ready <= 1'b0;
            error_count     = 0;
        end
        else
        begin
            if (digest_ch.valid && digest_ch.ready)
            begin
                if (expected_digest.size() == 0)
                begin
                    $display("%0t unexpected digest word: expected none, actual %h/%0d/%0b",
                             $time, digest_ch.digest_word, digest_ch.word_number,
                             digest_ch.final_word);
                    error_count++;
                end
                else
                begin
                    x = expected_digest.pop_front();
                    if (digest_ch.digest_word !== x.word)
                    begin
                        $display("%0t digest_word: expected %h, actual %h",
                                 $time, x.word, digest_ch.digest_word);
                        error_count++;
                    end
                    if (digest_ch.word_number !== x.num)
                    begin
                        $display("%0t word_number: expected %0d, actual %0d",
                                 $time, x.num, digest_ch.word_number);
                        error_count++;
                    end
                    if (digest_ch.final_word !== x.fin)
                    begin
                        $display("%0t final_word: expected %0b, actual %0b",
                                 $time, x.fin, digest_ch.final_word);
                        error_count++;
                    end
                end
            end
            case (load_phase)
                0:       recv_idle = 66;
                1:       recv_idle = 19;
                default: recv_idle = 0;
            endcase
            digest_ch.ready <= (stall_left == 0) && ($urandom_range(0, 99) >= recv_idle);
        end
    end

endmodule
